// File: rtl/gnnt_pkg.sv
// shared types, widths and codes of the gated nearest-neighbor tracker
package gnnt_pkg;

    // fixed field widths
    localparam int COORD_W = 12;
    localparam int GATE_W  = 12;
    localparam int SLOT_W  = 7;
    localparam int STAT_W  = 2;

    // distance widths: one square, sum of two squares, running minimum
    localparam int SQ_W   = 2 * GATE_W;
    localparam int DIST_W = SQ_W + 1;
    localparam int BEST_W = 27;

    // defaults of the top level parameters
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 12;

    // reset value of the gate radius and start of the minimum search
    localparam logic [GATE_W-1:0] GATE_RESET   = 12'd50;
    localparam logic [BEST_W-1:0] SEARCH_START = 27'd100000000;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_MATCH   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NEW     = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NO_PREV = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_DROP    = 2'd3;

    // sideband that travels with each operand pair through the distance unit
    typedef struct packed {
        logic valid;
        logic gate;
        logic claimed;
    } t_tag;

endpackage

// File: rtl/gnnt_dist_unit.sv
// two-stage squared distance unit shared by the gate square and the candidate scan
module gnnt_dist_unit #(
    parameter int IDX_W = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gnnt_pkg::t_tag              i_tag,
    input  logic [IDX_W-1:0]            i_idx,
    input  logic [gnnt_pkg::GATE_W-1:0] i_ax,
    input  logic [gnnt_pkg::GATE_W-1:0] i_bx,
    input  logic [gnnt_pkg::GATE_W-1:0] i_ay,
    input  logic [gnnt_pkg::GATE_W-1:0] i_by,
    output gnnt_pkg::t_tag              o_tag,
    output logic [IDX_W-1:0]            o_idx,
    output logic [gnnt_pkg::DIST_W-1:0] o_dist,
    output logic                        o_busy
);

    logic [gnnt_pkg::GATE_W-1:0] dx;
    logic [gnnt_pkg::GATE_W-1:0] dy;
    logic [gnnt_pkg::SQ_W-1:0]   r_sqx;
    logic [gnnt_pkg::SQ_W-1:0]   r_sqy;
    logic [gnnt_pkg::DIST_W-1:0] r_dist;
    gnnt_pkg::t_tag              r_tag_a;
    gnnt_pkg::t_tag              r_tag_b;
    logic [IDX_W-1:0]            r_idx_a;
    logic [IDX_W-1:0]            r_idx_b;

    // absolute differences
    assign dx = (i_ax > i_bx) ? (i_ax - i_bx) : (i_bx - i_ax);
    assign dy = (i_ay > i_by) ? (i_ay - i_by) : (i_by - i_ay);

    // tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
        end else begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
        end
    end

    // stage a squares, stage b sums
    always_ff @(posedge i_clk) begin
        r_sqx   <= gnnt_pkg::SQ_W'(dx) * gnnt_pkg::SQ_W'(dx);
        r_sqy   <= gnnt_pkg::SQ_W'(dy) * gnnt_pkg::SQ_W'(dy);
        r_idx_a <= i_idx;
        r_dist  <= gnnt_pkg::DIST_W'(r_sqx) + gnnt_pkg::DIST_W'(r_sqy);
        r_idx_b <= r_idx_a;
    end

    assign o_tag  = r_tag_b;
    assign o_idx  = r_idx_b;
    assign o_dist = r_dist;
    assign o_busy = r_tag_a.valid | r_tag_b.valid;

endmodule

// File: rtl/gated_nearest_neighbor_tracker.sv
// Gated nearest-neighbor point tracker: one point in, one slot assignment out.
// A beat for an empty frame, a dropped point or a point with no previous frame goes straight to
// the result register; any other point runs a search (setup, scan of the previous frame, drain).
// One item is handled at a time: the next beat is taken only once the result is loaded,
// so a stalled result holds off the next beat.
// Reset (synchronous, active low) clears counts, bank, claims and sets the gate to 50.
module gated_nearest_neighbor_tracker #(
    parameter int MAX_POINTS = gnnt_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = gnnt_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input point channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [gnnt_pkg::COORD_W-1:0] i_pos_x,
    input  logic [gnnt_pkg::COORD_W-1:0] i_pos_y,
    input  logic                         i_frame_end,
    input  logic                         i_frame_empty,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [gnnt_pkg::STAT_W-1:0]  o_status,
    output logic [gnnt_pkg::SLOT_W-1:0]  o_slot,
    output logic                         o_last,
    // gate radius write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gnnt_pkg::GATE_W-1:0]  i_cfg_data
);

    localparam int CW     = (COORD_BITS < gnnt_pkg::COORD_W) ? COORD_BITS : gnnt_pkg::COORD_W;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DEPTH  = 2 * MAX_POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = (CNT_W + 1 > gnnt_pkg::SLOT_W) ? CNT_W + 1 : gnnt_pkg::SLOT_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [gnnt_pkg::GATE_W-1:0]  r_gate;
    logic [gnnt_pkg::SQ_W-1:0]    r_gate_sq;
    logic                         r_bank;
    logic [CNT_W-1:0]             r_prev_count;
    logic [CNT_W-1:0]             r_cur_count;
    logic [CNT_W-1:0]             r_app_count;
    logic [MAX_POINTS-1:0]        r_claimed;
    logic [CW-1:0]                r_px;
    logic [CW-1:0]                r_py;
    logic                         r_last_in;
    logic                         r_stored;
    logic                         r_fast;
    logic [gnnt_pkg::STAT_W-1:0]  r_fast_status;
    logic [IDX_W-1:0]             r_j;
    logic                         r_v1;
    logic                         r_claim1;
    logic [IDX_W-1:0]             r_idx1;
    logic [2*CW-1:0]              r_rd_data;
    logic [gnnt_pkg::BEST_W-1:0]  r_best;
    logic [IDX_W-1:0]             r_best_j;
    logic                         r_found;
    logic                         r_out_valid;
    logic [gnnt_pkg::STAT_W-1:0]  r_status;
    logic [gnnt_pkg::SLOT_W-1:0]  r_slot;
    logic                         r_last;
    logic [2*CW-1:0]              mem [0:DEPTH-1];

    logic                         in_beat;
    logic                         cfg_beat;
    logic                         out_load;
    logic                         cur_full;
    logic                         scan_last;
    logic [CW-1:0]                px_m;
    logic [CW-1:0]                py_m;
    logic [ADDR_W-1:0]            wr_addr;
    logic [ADDR_W-1:0]            rd_addr;
    logic [CNT_W-1:0]             cur_next;
    logic [SUM_W-1:0]             slot_new_w;
    logic [SUM_W-1:0]             slot_match_w;
    logic [gnnt_pkg::STAT_W-1:0]  res_status;
    logic [gnnt_pkg::SLOT_W-1:0]  res_slot;
    logic                         setup;
    gnnt_pkg::t_tag               du_tag_in;
    gnnt_pkg::t_tag               du_tag;
    logic [IDX_W-1:0]             du_idx;
    logic [gnnt_pkg::DIST_W-1:0]  du_dist;
    logic                         du_busy;
    logic [gnnt_pkg::GATE_W-1:0]  du_ax;
    logic [gnnt_pkg::GATE_W-1:0]  du_bx;
    logic [gnnt_pkg::GATE_W-1:0]  du_ay;
    logic [gnnt_pkg::GATE_W-1:0]  du_by;
    logic                         take_cand;

    // handshakes
    assign o_stall     = (r_state != ST_IDLE);
    assign in_beat     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_beat    = i_cfg_valid && o_cfg_ready;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    // coordinates masked to the configured precision
    assign px_m = i_pos_x[CW-1:0];
    assign py_m = i_pos_y[CW-1:0];

    // bank addressing: current bank written, previous bank scanned
    assign cur_full  = (r_cur_count == CNT_W'(MAX_POINTS));
    assign wr_addr   = r_bank ? (ADDR_W'(MAX_POINTS) + ADDR_W'(r_cur_count))
                              : ADDR_W'(r_cur_count);
    assign rd_addr   = r_bank ? ADDR_W'(r_j) : (ADDR_W'(MAX_POINTS) + ADDR_W'(r_j));
    assign scan_last = ((CNT_W'(r_j) + CNT_W'(1)) == r_prev_count);

    // point memory
    always_ff @(posedge i_clk) begin
        if (in_beat && !i_frame_empty && !cur_full) begin
            mem[wr_addr] <= {px_m, py_m};
        end
        r_rd_data <= mem[rd_addr];
    end

    // distance unit operands: gate radius during setup, candidates afterwards
    assign setup             = (r_state == ST_SETUP);
    assign du_ax             = setup ? r_gate : gnnt_pkg::GATE_W'(r_px);
    assign du_bx             = setup ? '0 : gnnt_pkg::GATE_W'(r_rd_data[2*CW-1:CW]);
    assign du_ay             = setup ? '0 : gnnt_pkg::GATE_W'(r_py);
    assign du_by             = setup ? '0 : gnnt_pkg::GATE_W'(r_rd_data[CW-1:0]);
    assign du_tag_in.valid   = setup | r_v1;
    assign du_tag_in.gate    = setup;
    assign du_tag_in.claimed = r_claim1;

    gnnt_dist_unit #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (du_tag_in),
        .i_idx   (r_idx1),
        .i_ax    (du_ax),
        .i_bx    (du_bx),
        .i_ay    (du_ay),
        .i_by    (du_by),
        .o_tag   (du_tag),
        .o_idx   (du_idx),
        .o_dist  (du_dist),
        .o_busy  (du_busy)
    );

    // candidate wins when unclaimed, inside the gate and below the running minimum
    assign take_cand = du_tag.valid && !du_tag.gate && !du_tag.claimed &&
                       (gnnt_pkg::BEST_W'(du_dist) < r_best) &&
                       (du_dist < gnnt_pkg::DIST_W'(r_gate_sq));

    // result assembly
    assign cur_next     = r_cur_count + CNT_W'(r_stored);
    assign slot_new_w   = SUM_W'(r_prev_count) + SUM_W'(r_app_count);
    assign slot_match_w = SUM_W'(r_best_j);

    always_comb begin
        if (r_fast) begin
            res_status = r_fast_status;
            res_slot   = '0;
        end else if (r_found) begin
            res_status = gnnt_pkg::STATUS_MATCH;
            res_slot   = slot_match_w[gnnt_pkg::SLOT_W-1:0];
        end else begin
            res_status = gnnt_pkg::STATUS_NEW;
            res_slot   = slot_new_w[gnnt_pkg::SLOT_W-1:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    if (i_frame_empty || cur_full || (r_prev_count == '0)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !du_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // accepted point and scan pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_px <= px_m;
            r_py <= py_m;
        end
        r_idx1   <= r_j;
        r_claim1 <= r_claimed[r_j];
        if (out_load) begin
            r_status <= res_status;
            r_slot   <= res_slot;
            r_last   <= r_last_in;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_gate        <= gnnt_pkg::GATE_RESET;
            r_gate_sq     <= '0;
            r_bank        <= 1'b0;
            r_prev_count  <= '0;
            r_cur_count   <= '0;
            r_app_count   <= '0;
            r_claimed     <= '0;
            r_last_in     <= 1'b0;
            r_stored      <= 1'b0;
            r_fast        <= 1'b0;
            r_fast_status <= gnnt_pkg::STATUS_NO_PREV;
            r_j           <= '0;
            r_v1          <= 1'b0;
            r_best        <= gnnt_pkg::SEARCH_START;
            r_best_j      <= '0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == ST_SCAN);

            // gate radius register
            if (cfg_beat) begin
                r_gate <= i_cfg_data;
            end

            // take the point and decide the path
            if (in_beat) begin
                r_last_in <= i_frame_end | i_frame_empty;
                r_j       <= '0;
                r_best    <= gnnt_pkg::SEARCH_START;
                r_found   <= 1'b0;
                if (i_frame_empty) begin
                    r_fast        <= 1'b1;
                    r_fast_status <= gnnt_pkg::STATUS_NO_PREV;
                    r_stored      <= 1'b0;
                end else if (cur_full) begin
                    r_fast        <= 1'b1;
                    r_fast_status <= gnnt_pkg::STATUS_DROP;
                    r_stored      <= 1'b0;
                end else begin
                    r_fast        <= (r_prev_count == '0);
                    r_fast_status <= gnnt_pkg::STATUS_NO_PREV;
                    r_stored      <= 1'b1;
                end
            end

            // scan index
            if (r_state == ST_SCAN) begin
                r_j <= r_j + IDX_W'(1);
            end

            // gate square and running minimum
            if (du_tag.valid && du_tag.gate) begin
                r_gate_sq <= du_dist[gnnt_pkg::SQ_W-1:0];
            end
            if (take_cand) begin
                r_best   <= gnnt_pkg::BEST_W'(du_dist);
                r_best_j <= du_idx;
                r_found  <= 1'b1;
            end

            // result register
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (r_last_in) begin
                    r_bank       <= ~r_bank;
                    r_prev_count <= cur_next;
                    r_cur_count  <= '0;
                    r_app_count  <= '0;
                    r_claimed    <= '0;
                end else begin
                    r_cur_count <= cur_next;
                    if (!r_fast && r_found) begin
                        r_claimed[r_best_j] <= 1'b1;
                    end
                    if (!r_fast && !r_found) begin
                        r_app_count <= r_app_count + CNT_W'(1);
                    end
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_slot   = r_slot;
    assign o_last   = r_last;

`ifndef SYNTHESIS
    // matched slot always lies inside the previous frame
    a_match_in_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_fast && r_found) |-> (CNT_W'(r_best_j) < r_prev_count))
        else $error("matched slot beyond previous count");

    // current count never passes capacity
    a_cur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_count <= CNT_W'(MAX_POINTS))
        else $error("current count beyond capacity");

    // the scan pipeline is empty whenever a new point may enter
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_v1 && !du_busy))
        else $error("scan pipeline busy while idle");
`endif

endmodule
